### hw/rtl/cdp_pkg.sv
// shared types and constants for the compound duration parser
`default_nettype none

package cdp_pkg;

	localparam int SECONDS_OUT_W = 48;

	typedef enum logic [1:0] {
		ST_DURATION  = 2'd0,
		ST_PERMANENT = 2'd1,
		ST_INVALID   = 2'd2,
		ST_OVERFLOW  = 2'd3
	} status_t;

	// match position codes
	localparam logic [3:0] PERM_DEAD      = 4'd15;
	localparam logic [3:0] PERM_SHORT_LEN = 4'd5;
	localparam logic [3:0] PERM_FULL_LEN  = 4'd9;

	// character codes
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UP_A  = 8'h41;
	localparam logic [7:0] CH_UP_Z  = 8'h5a;
	localparam logic [7:0] CH_CASE  = 8'h20;
	localparam logic [7:0] CH_H     = 8'h68;
	localparam logic [7:0] CH_M     = 8'h6d;
	localparam logic [7:0] CH_S     = 8'h73;

	// unit scale factors
	localparam logic [11:0] SCALE_H = 12'd3600;
	localparam logic [11:0] SCALE_M = 12'd60;
	localparam logic [11:0] SCALE_S = 12'd1;

	// expected lower-case letter at each match position
	function automatic logic [7:0] perm_char(input logic [3:0] pos);
		logic [7:0] ch;
		case (pos)
			4'd0: ch = 8'h70; // p
			4'd1: ch = 8'h65; // e
			4'd2: ch = 8'h72; // r
			4'd3: ch = 8'h6d; // m
			4'd4: ch = 8'h61; // a
			4'd5: ch = 8'h6e; // n
			4'd6: ch = 8'h65; // e
			4'd7: ch = 8'h6e; // n
			4'd8: ch = 8'h74; // t
			default: ch = 8'h00;
		endcase
		return ch;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/compound_duration_parser_core.sv
// top level of the compound duration parser: byte stream in, status and seconds out
//
//  channel | dir | handshake           | payload
//  --------+-----+---------------------+-------------------------------------
//  in      | in  | in_valid / in_ready | char_code[7:0], is_last, no_char
//  out     | out | out_valid/out_ready | status[1:0], seconds[47:0]
//
//  one word per cycle sustained while the result register is not blocked; a word is
//  registered, then folded into the accumulators in the next cycle, and a last word loads
//  the result register, which raises out_valid once the result register is free
//  arst_n clears the pipeline valid bits and all accumulators
//  only a stalled result backs up: a registered last word waits for the result
//  register, and in_ready drops until it can move on
`default_nettype none

module compound_duration_parser_core #(
	parameter int SECONDS_WIDTH = 48
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [7:0]                        char_code,
	input  wire logic                              is_last,
	input  wire logic                              no_char,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [1:0]                             status,
	output logic [cdp_pkg::SECONDS_OUT_W-1:0]      seconds
);

	localparam int W = SECONDS_WIDTH;

	// input register
	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;
	logic       nochar_s1;

	// accumulators
	logic [W-1:0] number_q;
	logic [W-1:0] total_q;
	logic         unit_q;
	logic         bad_q;
	logic         ovf_q;
	logic [3:0]   perm_q;

	// result register
	logic                                 out_valid_q;
	cdp_pkg::status_t                     status_q;
	logic [cdp_pkg::SECONDS_OUT_W-1:0]    seconds_q;

	logic proc;
	logic in_fire;

	assign proc     = valid_s1 && (!last_s1 || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || proc;
	assign in_fire  = in_valid && in_ready;

	// per-word update
	logic [7:0]    c_lc;
	logic          is_digit;
	logic          is_h;
	logic          is_m;
	logic          is_s;
	logic          is_unit;
	logic [3:0]    digit;
	logic [W+3:0]  prod10;
	logic          ovf10;
	logic [W+12:0] sc_h;
	logic [W+12:0] sc_m;
	logic [W+12:0] sc_s;
	logic [W+12:0] scaled;
	logic [W+12:0] sumu;
	logic          ovfu;

	logic [W-1:0]  num_n;
	logic [W-1:0]  tot_n;
	logic          unit_n;
	logic          bad_n;
	logic          ovf_n;
	logic [3:0]    perm_n;

	logic [W:0]    fsum;
	cdp_pkg::status_t                  res_status;
	logic [W-1:0]                      res_secs;

	always_comb begin
		c_lc = char_s1;
		if (char_s1 >= cdp_pkg::CH_UP_A && char_s1 <= cdp_pkg::CH_UP_Z) begin
			c_lc = char_s1 | cdp_pkg::CH_CASE;
		end
		is_digit = (c_lc >= cdp_pkg::CH_0) && (c_lc <= cdp_pkg::CH_9);
		is_h     = (c_lc == cdp_pkg::CH_H);
		is_m     = (c_lc == cdp_pkg::CH_M);
		is_s     = (c_lc == cdp_pkg::CH_S);
		is_unit  = is_h || is_m || is_s;
		digit    = 4'(c_lc - cdp_pkg::CH_0);

		prod10 = ((W+4)'(number_q) << 3) + ((W+4)'(number_q) << 1) + (W+4)'(digit);
		ovf10  = |prod10[W+3:W];

		sc_h   = (W+13)'(number_q) * (W+13)'(cdp_pkg::SCALE_H);
		sc_m   = (W+13)'(number_q) * (W+13)'(cdp_pkg::SCALE_M);
		sc_s   = (W+13)'(number_q) * (W+13)'(cdp_pkg::SCALE_S);
		scaled = is_h ? sc_h : (is_m ? sc_m : sc_s);
		sumu   = scaled + (W+13)'(total_q);
		ovfu   = |sumu[W+12:W];

		num_n  = number_q;
		tot_n  = total_q;
		unit_n = unit_q;
		bad_n  = bad_q;
		ovf_n  = ovf_q;
		perm_n = cdp_pkg::PERM_DEAD;

		if (nochar_s1) begin
			bad_n = 1'b1;
		end else begin
			if (perm_q < cdp_pkg::PERM_FULL_LEN && c_lc == cdp_pkg::perm_char(perm_q)) begin
				perm_n = perm_q + 4'd1;
			end
			if (is_digit) begin
				if (!ovf_q) begin
					if (ovf10) begin
						ovf_n = 1'b1;
					end else begin
						num_n = prod10[W-1:0];
					end
				end
			end else if (is_unit) begin
				unit_n = 1'b1;
				if (!ovf_q) begin
					if (ovfu) begin
						ovf_n = 1'b1;
					end else begin
						tot_n = sumu[W-1:0];
						num_n = '0;
					end
				end
			end else begin
				bad_n = 1'b1;
			end
		end

		// end of text resolution
		fsum       = {1'b0, tot_n} + {1'b0, num_n};
		res_secs   = '0;
		res_status = cdp_pkg::ST_DURATION;
		if (perm_n == cdp_pkg::PERM_SHORT_LEN || perm_n == cdp_pkg::PERM_FULL_LEN) begin
			res_status = cdp_pkg::ST_PERMANENT;
		end else if (bad_n) begin
			res_status = cdp_pkg::ST_INVALID;
		end else if (ovf_n) begin
			res_status = cdp_pkg::ST_OVERFLOW;
		end else if (num_n != '0) begin
			if (fsum[W]) begin
				res_status = cdp_pkg::ST_OVERFLOW;
			end else begin
				res_secs = fsum[W-1:0];
			end
		end else if (!unit_n) begin
			res_status = cdp_pkg::ST_INVALID;
		end else begin
			res_secs = tot_n;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (proc) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			char_s1   <= char_code;
			last_s1   <= is_last;
			nochar_s1 <= no_char;
		end
	end

	// accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_q <= '0;
			total_q  <= '0;
			unit_q   <= 1'b0;
			bad_q    <= 1'b0;
			ovf_q    <= 1'b0;
			perm_q   <= '0;
		end else if (proc) begin
			if (last_s1) begin
				number_q <= '0;
				total_q  <= '0;
				unit_q   <= 1'b0;
				bad_q    <= 1'b0;
				ovf_q    <= 1'b0;
				perm_q   <= '0;
			end else begin
				number_q <= num_n;
				total_q  <= tot_n;
				unit_q   <= unit_n;
				bad_q    <= bad_n;
				ovf_q    <= ovf_n;
				perm_q   <= perm_n;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (proc && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && last_s1) begin
			status_q  <= res_status;
			seconds_q <= cdp_pkg::SECONDS_OUT_W'(res_secs);
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign seconds   = seconds_q;

	// checks
	a_nondur_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && status_q != cdp_pkg::ST_DURATION |-> seconds_q == '0)
		else $error("nonzero seconds with non-duration status");

	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		proc && last_s1 |=> number_q == '0 && total_q == '0 && perm_q == '0
			&& !unit_q && !bad_q && !ovf_q)
		else $error("state not cleared after last word");

	a_perm_range: assert property (@(posedge clk) disable iff (!arst_n)
		perm_q <= cdp_pkg::PERM_FULL_LEN || perm_q == cdp_pkg::PERM_DEAD)
		else $error("match position out of range");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && last_s1 && out_valid_q && !out_ready)
		else $error("input stalled without a blocked result");

endmodule

`default_nettype wire

### bench/tb.sv
// testbench for compound_duration_parser_core: random and directed duration texts
`timescale 1ns / 1ps

module tb;

	localparam int SECONDS_WIDTH = 48;
	localparam logic [63:0] SEC_LIMIT = (64'd1 << SECONDS_WIDTH) - 64'd1;
	localparam string PERM_WORD = "permanent";
	localparam int STALL_LIMIT = 4000;

	typedef struct packed {
		logic [7:0] ch;
		logic       empty;
	} text_byte_t;

	typedef struct packed {
		cdp_pkg::status_t status;
		logic [47:0]      seconds;
	} parse_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  char_code = 8'd0;
	logic        is_last = 1'b0;
	logic        no_char = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  status;
	logic [cdp_pkg::SECONDS_OUT_W-1:0] seconds;

	// parser model state
	logic [63:0] num_acc = '0;
	logic [63:0] total_sec = '0;
	logic        saw_unit = 1'b0;
	logic        saw_bad = 1'b0;
	logic        saw_ovf = 1'b0;
	logic [3:0]  perm_pos = '0;

	parse_result_t expected_q[$];
	text_byte_t    text_q[$];

	int unsigned send_gap_pct = 0;
	int unsigned recv_gap_pct = 0;
	int          items_sent = 0;
	int          stall_cycles = 0;
	bit          failed = 1'b0;

	compound_duration_parser_core #(
		.SECONDS_WIDTH(SECONDS_WIDTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.is_last(is_last),
		.no_char(no_char),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.status(status),
		.seconds(seconds)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void scale_into_total(input logic [63:0] k);
		if (saw_ovf)
			return;
		if (num_acc > (SEC_LIMIT - total_sec) / k)
			saw_ovf = 1'b1;
		else
			total_sec = total_sec + num_acc * k;
	endfunction

	function automatic void take_unit(input logic [63:0] k);
		scale_into_total(k);
		if (!saw_ovf)
			num_acc = '0;
		saw_unit = 1'b1;
	endfunction

	function automatic void parse_byte(input logic [7:0] code, input logic last,
			input logic empty);
		logic [7:0]    c;
		logic [63:0]   digit;
		logic          any_unit;
		parse_result_t res;
		c = code;
		if (empty) begin
			saw_bad = 1'b1;
			perm_pos = cdp_pkg::PERM_DEAD;
		end else begin
			if (c >= cdp_pkg::CH_UP_A && c <= cdp_pkg::CH_UP_Z)
				c = c + cdp_pkg::CH_CASE;
			if (perm_pos < cdp_pkg::PERM_FULL_LEN && c == PERM_WORD[perm_pos])
				perm_pos = perm_pos + 4'd1;
			else
				perm_pos = cdp_pkg::PERM_DEAD;
			if (c >= cdp_pkg::CH_0 && c <= cdp_pkg::CH_9) begin
				digit = 64'(c - cdp_pkg::CH_0);
				if (!saw_ovf) begin
					if (num_acc > (SEC_LIMIT - digit) / 64'd10)
						saw_ovf = 1'b1;
					else
						num_acc = num_acc * 64'd10 + digit;
				end
			end else if (c == cdp_pkg::CH_H) begin
				take_unit(64'(cdp_pkg::SCALE_H));
			end else if (c == cdp_pkg::CH_M) begin
				take_unit(64'(cdp_pkg::SCALE_M));
			end else if (c == cdp_pkg::CH_S) begin
				take_unit(64'(cdp_pkg::SCALE_S));
			end else begin
				saw_bad = 1'b1;
			end
		end
		if (!last)
			return;
		res.seconds = '0;
		if (perm_pos == cdp_pkg::PERM_SHORT_LEN || perm_pos == cdp_pkg::PERM_FULL_LEN) begin
			res.status = cdp_pkg::ST_PERMANENT;
		end else if (saw_bad) begin
			res.status = cdp_pkg::ST_INVALID;
		end else if (saw_ovf) begin
			res.status = cdp_pkg::ST_OVERFLOW;
		end else begin
			any_unit = saw_unit;
			if (num_acc != 0) begin
				scale_into_total(64'd1);
				any_unit = 1'b1;
			end
			if (saw_ovf) begin
				res.status = cdp_pkg::ST_OVERFLOW;
			end else if (!any_unit) begin
				res.status = cdp_pkg::ST_INVALID;
			end else begin
				res.status = cdp_pkg::ST_DURATION;
				res.seconds = total_sec[47:0];
			end
		end
		expected_q.insert(expected_q.size(), res);
		num_acc = '0;
		total_sec = '0;
		saw_unit = 1'b0;
		saw_bad = 1'b0;
		saw_ovf = 1'b0;
		perm_pos = '0;
	endfunction

	task automatic send_word(input logic [7:0] code, input logic last, input logic empty);
		while ($urandom_range(0, 99) < send_gap_pct) begin
			if (in_valid)
				in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		char_code <= code;
		is_last <= last;
		no_char <= empty;
		do @(posedge clk); while (!in_ready);
		parse_byte(code, last, empty);
		items_sent++;
	endtask

	task automatic send_text();
		foreach (text_q[i])
			send_word(text_q[i].ch, i == text_q.size() - 1, text_q[i].empty);
		text_q.delete();
	endtask

	task automatic wait_drained();
		if (in_valid) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		while (expected_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] mixed_case(input logic [7:0] c);
		if (c >= cdp_pkg::CH_UP_A + cdp_pkg::CH_CASE
				&& c <= cdp_pkg::CH_UP_Z + cdp_pkg::CH_CASE && $urandom_range(0, 1) == 1)
			return c - cdp_pkg::CH_CASE;
		return c;
	endfunction

	function automatic logic [7:0] pick_unit();
		case ($urandom_range(0, 2))
			0: return mixed_case(cdp_pkg::CH_H);
			1: return mixed_case(cdp_pkg::CH_M);
			default: return mixed_case(cdp_pkg::CH_S);
		endcase
	endfunction

	function automatic void push_char(input logic [7:0] c);
		text_q.insert(text_q.size(), text_byte_t'{ch: c, empty: 1'b0});
	endfunction

	function automatic void push_empty();
		text_q.insert(text_q.size(), text_byte_t'{ch: 8'($urandom_range(0, 255)), empty: 1'b1});
	endfunction

	function automatic void push_number(input int digits);
		repeat (digits)
			push_char(cdp_pkg::CH_0 + 8'($urandom_range(0, 9)));
	endfunction

	function automatic void queue_string(input string s);
		foreach (s[i])
			push_char(s[i]);
	endfunction

	function automatic void queue_duration(input int max_digits);
		int groups;
		groups = $urandom_range(0, 4);
		repeat (groups) begin
			push_number($urandom_range(0, max_digits));
			push_char(pick_unit());
		end
		if (groups == 0 || $urandom_range(0, 1) == 1)
			push_number($urandom_range(1, max_digits));
	endfunction

	function automatic void queue_perm_word(input int len);
		for (int i = 0; i < len; i++)
			push_char(mixed_case(PERM_WORD[i]));
	endfunction

	task automatic test_directed();
		queue_string("2H30m15S");
		send_text();
		queue_string("PeRmA");
		send_text();
		queue_string("pERMANENT");
		send_text();
		push_empty();
		send_text();
		queue_string("0");
		send_text();
		queue_string("s");
		send_text();
		push_char(8'hff);
		send_text();
		queue_string("9");
		send_text();
	endtask

	task automatic test_durations(input int target);
		int start;
		start = items_sent;
		while (items_sent - start < target) begin
			queue_duration($urandom_range(0, 7) == 0 ? 8 : 4);
			send_text();
			if ($urandom_range(0, 29) == 0)
				wait_drained();
		end
	endtask

	task automatic test_permanent_words(input int target);
		int start;
		int pos;
		int kind;
		start = items_sent;
		while (items_sent - start < target) begin
			kind = $urandom_range(0, 9);
			if (kind == 5)
				queue_perm_word($urandom_range(1, 8));
			else
				queue_perm_word($urandom_range(0, 1) == 1 ? 9 : 5);
			pos = $urandom_range(0, text_q.size() - 1);
			case (kind)
				6: push_char($urandom_range(0, 1) == 1 ? 8'($urandom_range(0, 255)) :
					mixed_case(PERM_WORD[$urandom_range(0, 8)]));
				7: text_q[pos].ch = 8'($urandom_range(0, 255));
				8: text_q.insert(pos, text_byte_t'{ch: 8'($urandom_range(0, 255)), empty: 1'b1});
				9: text_q.push_front(text_byte_t'{ch: cdp_pkg::CH_0 + 8'($urandom_range(0, 9)),
					empty: 1'b0});
				default: ;
			endcase
			send_text();
		end
	endtask

	task automatic test_overflow(input int target);
		int start;
		start = items_sent;
		queue_string("281474976710655");
		send_text();
		queue_string("281474976710656");
		send_text();
		while (items_sent - start < target) begin
			case ($urandom_range(0, 2))
				0: push_number($urandom_range(14, 17));
				1: begin
					repeat ($urandom_range(1, 3)) begin
						push_number($urandom_range(9, 14));
						push_char(pick_unit());
					end
					if ($urandom_range(0, 1) == 1)
						push_number($urandom_range(1, 15));
				end
				default: begin
					push_number($urandom_range(15, 17));
					if ($urandom_range(0, 1) == 1)
						push_empty();
					else
						push_char(8'($urandom_range(0, 255)));
				end
			endcase
			send_text();
		end
	endtask

	task automatic test_malformed(input int target);
		int start;
		int pos;
		start = items_sent;
		while (items_sent - start < target) begin
			case ($urandom_range(0, 3))
				0: begin
					repeat ($urandom_range(1, 8)) begin
						if ($urandom_range(0, 9) == 0)
							push_empty();
						else
							push_char(8'($urandom_range(0, 255)));
					end
				end
				1: begin
					queue_duration(4);
					pos = $urandom_range(0, text_q.size() - 1);
					if ($urandom_range(0, 3) == 0)
						text_q[pos].empty = 1'b1;
					else
						text_q[pos].ch = 8'($urandom_range(0, 255));
				end
				2: push_empty();
				default: begin
					repeat ($urandom_range(1, 3))
						push_char(cdp_pkg::CH_0);
					if ($urandom_range(0, 1) == 1)
						push_char(pick_unit());
				end
			endcase
			send_text();
		end
	endtask

	always @(posedge clk) begin : check_results
		parse_result_t want;
		if (out_valid && out_ready) begin
			if (expected_q.size() == 0) begin
				$error("unexpected word: status %0d seconds %0d", status, seconds);
				failed = 1'b1;
			end else begin
				want = expected_q.pop_front();
				if (status !== want.status) begin
					$error("status mismatch: expected %0d, actual %0d", want.status, status);
					failed = 1'b1;
				end
				if (seconds !== want.seconds) begin
					$error("seconds mismatch: expected %0d, actual %0d", want.seconds, seconds);
					failed = 1'b1;
				end
			end
		end
		out_ready <= ($urandom_range(0, 99) >= recv_gap_pct);
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("** compound_duration_parser_core: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_gap_pct = 24;
		recv_gap_pct = 78;
		test_directed();
		for (int phase = 0; phase < 3; phase++) begin
			send_gap_pct = (phase == 0) ? 24 : (phase == 1) ? 78 : 0;
			recv_gap_pct = (phase == 0) ? 78 : (phase == 1) ? 24 : 0;
			test_durations(340);
			test_permanent_words(90);
			test_overflow(90);
			test_malformed(80);
			wait_drained();
		end
		repeat (10) @(posedge clk);
		if (!failed)
			$display("** compound_duration_parser_core: PASSED **");
		else
			$display("** compound_duration_parser_core: FAILED **");
		$finish;
	end

endmodule
